// File: design/box_blur_3x3_clipped_unit_defines.svh
// Assertion macros shared by the checker of the 3x3 box blur unit.
// No dependencies; the checker file includes this header.
`ifndef BOX_BLUR_3X3_CLIPPED_UNIT_DEFINES_SVH
`define BOX_BLUR_3X3_CLIPPED_UNIT_DEFINES_SVH

// Concurrent assertion that is switched off while reset is high.
`define BB3_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Concurrent assertion that also covers the reset cycles.
`define BB3_ASSERT_RESET(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// File: design/bb3_pkg.sv
// Shared types, constants and helper functions of the 3x3 box blur unit.
// No dependencies; the top level, bb3_line_store, bb3_window and bb3_out_fifo import it.
package bb3_pkg;

   localparam int CH_W           = 8;
   localparam int PIX_W          = 3 * CH_W;
   localparam int SUM_W          = 12;
   localparam int RECIP_W        = 14;
   localparam int RECIP_SHIFT    = 15;
   localparam int PROD_W         = SUM_W + RECIP_W;
   localparam int FIFO_DEPTH     = 8;
   localparam int FIFO_PTR_W     = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W     = FIFO_PTR_W + 1;
   localparam int FRAME_WIDTH_W  = 11;
   localparam int FRAME_HEIGHT_W = 13;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;
   localparam int FRAME_WIDTH_RESET  = 640;
   localparam int FRAME_HEIGHT_RESET = 480;

   typedef enum logic {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } bb3_reg_type;

   typedef enum logic [1:0] {
      DIV_BY_4,
      DIV_BY_6,
      DIV_BY_9
   } bb3_divisor_type;

   typedef struct packed {
      logic result;
      logic top_en;
      logic bottom_en;
      logic left_en;
      logic right_en;
      logic frame_end;
   } bb3_ctrl_type;

   typedef struct packed {
      logic [SUM_W-1:0] red;
      logic [SUM_W-1:0] green;
      logic [SUM_W-1:0] blue;
      bb3_divisor_type  divisor;
      logic             frame_end;
   } bb3_sum_type;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
      logic            frame_end;
   } bb3_result_type;

   function automatic bb3_divisor_type bb3_divisor_of(input bb3_ctrl_type ctrl);
      logic row_cut;
      logic col_cut;
      row_cut = !(ctrl.top_en && ctrl.bottom_en);
      col_cut = !(ctrl.left_en && ctrl.right_en);
      if (row_cut && col_cut) begin
         return DIV_BY_4;
      end else if (row_cut || col_cut) begin
         return DIV_BY_6;
      end
      return DIV_BY_9;
   endfunction

   // Half the divisor, added before the division so that halves round up.
   function automatic logic [SUM_W-1:0] bb3_half_of(input bb3_divisor_type divisor);
      case (divisor)
         DIV_BY_4: begin
            return SUM_W'(2);
         end
         DIV_BY_6: begin
            return SUM_W'(3);
         end
         DIV_BY_9: begin
            return SUM_W'(4);
         end
         default: begin
            return SUM_W'(4);
         end
      endcase
   endfunction

   // Reciprocal scaled by 2**RECIP_SHIFT; exact for every sum below 2**SUM_W.
   function automatic logic [RECIP_W-1:0] bb3_recip(input bb3_divisor_type divisor);
      case (divisor)
         DIV_BY_4: begin
            return RECIP_W'(8192);
         end
         DIV_BY_6: begin
            return RECIP_W'(5462);
         end
         DIV_BY_9: begin
            return RECIP_W'(3641);
         end
         default: begin
            return RECIP_W'(3641);
         end
      endcase
   endfunction

endpackage

// File: design/box_blur_3x3_clipped_unit.sv
// 3x3 box blur with clipped window over a raster RGB stream.
// Depends on bb3_pkg, bb3_line_store, bb3_window and bb3_out_fifo.
//
// Requests enter on the req_ channel, one pixel each, in raster order; a
// request with req_drain set is a flush tick. After the last pixel of a
// frame the host sends frame_width + 1 drain requests. The result for a
// pixel belongs to the request that arrives frame_width + 1 positions later,
// and it passes the line-store, window and sum registers into the output queue.
// Requests in the first row and the first request of the second row give
// no result.
// One request is accepted in every cycle with req_stall low; req_stall
// rises only when the eight-entry output queue, counted together with the
// three stages in flight, is full; the queue keeps the pipeline running
// while the receiver holds rsp_stall, and its head holds still until taken.
// Reset sets the frame to 640 x 480, clears the stream position, the window
// and the queue; the line memories are not cleared and need no pass.
// frame_width lies at byte 0 and frame_height at byte 4 of the APB port;
// any write clamps the value to its range and restarts the frame.
module box_blur_3x3_clipped_unit #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [bb3_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [bb3_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [bb3_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [bb3_pkg::CH_W-1:0]         req_pixel_red,
   input  logic [bb3_pkg::CH_W-1:0]         req_pixel_green,
   input  logic [bb3_pkg::CH_W-1:0]         req_pixel_blue,
   input  logic                             req_drain,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [bb3_pkg::CH_W-1:0]         rsp_blur_red,
   output logic [bb3_pkg::CH_W-1:0]         rsp_blur_green,
   output logic [bb3_pkg::CH_W-1:0]         rsp_blur_blue,
   output logic                             rsp_frame_end
);
   import bb3_pkg::*;

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int WDW = $clog2(MAX_WIDTH + 1);
   localparam int HDW = $clog2(MAX_HEIGHT + 1);
   localparam int RW  = $clog2(MAX_HEIGHT + 2);
   localparam int WIDTH_RESET  = (MAX_WIDTH < FRAME_WIDTH_RESET) ? MAX_WIDTH
                                                                 : FRAME_WIDTH_RESET;
   localparam int HEIGHT_RESET = (MAX_HEIGHT < FRAME_HEIGHT_RESET) ? MAX_HEIGHT
                                                                   : FRAME_HEIGHT_RESET;

   logic [WDW-1:0]        width_ff;
   logic [WDW-1:0]        width_in;
   logic [HDW-1:0]        height_ff;
   logic [HDW-1:0]        height_in;
   logic [CW-1:0]         col_ff;
   logic [CW-1:0]         col_in;
   logic [RW-1:0]         row_ff;
   logic [RW-1:0]         row_in;
   bb3_ctrl_type          ctrl1_ff;
   bb3_ctrl_type          ctrl_in;
   bb3_reg_type           reg_sel;
   logic                  csr_write;
   logic                  accept;
   logic [CSR_DATA_W-1:0] wr_width_raw;
   logic [CSR_DATA_W-1:0] wr_height_raw;
   logic [WDW-1:0]        col_ext;
   logic [WDW-1:0]        col_plus;
   logic [RW-1:0]         height_ext;
   logic [RW-1:0]         cen_row;
   logic [WDW-1:0]        cen_col;
   logic                  cen_ok;
   logic [PIX_W-1:0]      pixel_in;
   logic                  s1_valid;
   logic [PIX_W-1:0]      s1_upper;
   logic [PIX_W-1:0]      s1_lower;
   logic [PIX_W-1:0]      s1_pixel;
   logic                  sum_valid;
   bb3_sum_type           sum;
   logic [1:0]            pending;
   logic [FIFO_CNT_W-1:0] fifo_count;
   logic [FIFO_CNT_W:0]   occupancy;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign reg_sel   = bb3_reg_type'(paddr[2]);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      case (reg_sel)
         REG_FRAME_WIDTH: begin
            prdata = CSR_DATA_W'(width_ff);
         end
         REG_FRAME_HEIGHT: begin
            prdata = CSR_DATA_W'(height_ff);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_comb begin
      wr_width_raw  = CSR_DATA_W'(pwdata[FRAME_WIDTH_W-1:0]);
      wr_height_raw = CSR_DATA_W'(pwdata[FRAME_HEIGHT_W-1:0]);
      if (wr_width_raw < CSR_DATA_W'(2)) begin
         width_in = WDW'(2);
      end else if (wr_width_raw > CSR_DATA_W'(MAX_WIDTH)) begin
         width_in = WDW'(MAX_WIDTH);
      end else begin
         width_in = WDW'(wr_width_raw);
      end
      if (wr_height_raw < CSR_DATA_W'(2)) begin
         height_in = HDW'(2);
      end else if (wr_height_raw > CSR_DATA_W'(MAX_HEIGHT)) begin
         height_in = HDW'(MAX_HEIGHT);
      end else begin
         height_in = HDW'(wr_height_raw);
      end
   end

   // The window centre trails the stream position by one row and one column.
   always_comb begin
      col_ext    = WDW'(col_ff);
      col_plus   = col_ext + WDW'(1);
      height_ext = RW'(height_ff);
      if (col_ff != '0) begin
         cen_ok  = (row_ff != '0);
         cen_row = row_ff - RW'(1);
         cen_col = col_ext - WDW'(1);
      end else begin
         cen_ok  = (row_ff >= RW'(2));
         cen_row = row_ff - RW'(2);
         cen_col = width_ff - WDW'(1);
      end
      ctrl_in.result    = cen_ok && (cen_row < height_ext);
      ctrl_in.top_en    = (cen_row != '0);
      ctrl_in.bottom_en = (cen_row < height_ext - RW'(1));
      ctrl_in.left_en   = (cen_col != '0);
      ctrl_in.right_en  = (cen_col < width_ff - WDW'(1));
      ctrl_in.frame_end = ctrl_in.result && (cen_row == height_ext - RW'(1))
                          && (cen_col == width_ff - WDW'(1));

      if (!req_drain && (row_ff < height_ext)) begin
         pixel_in = {req_pixel_red, req_pixel_green, req_pixel_blue};
      end else begin
         pixel_in = '0;
      end

      if (ctrl_in.frame_end) begin
         col_in = '0;
         row_in = '0;
      end else if (col_plus >= width_ff) begin
         col_in = '0;
         row_in = row_ff + RW'(1);
      end else begin
         col_in = col_plus[CW-1:0];
         row_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WDW'(WIDTH_RESET);
         height_ff <= HDW'(HEIGHT_RESET);
         col_ff    <= '0;
         row_ff    <= '0;
      end else if (csr_write) begin
         case (reg_sel)
            REG_FRAME_WIDTH: begin
               width_ff <= width_in;
            end
            REG_FRAME_HEIGHT: begin
               height_ff <= height_in;
            end
            default: begin
               width_ff <= width_ff;
            end
         endcase
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ctrl1_ff <= ctrl_in;
      end
   end

   assign occupancy = (FIFO_CNT_W+1)'(fifo_count) + (FIFO_CNT_W+1)'(s1_valid)
                    + (FIFO_CNT_W+1)'(pending);
   assign req_stall = (occupancy >= (FIFO_CNT_W+1)'(FIFO_DEPTH));

   bb3_line_store #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_store (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .addr     (col_ff),
      .pixel    (pixel_in),
      .s1_valid (s1_valid),
      .s1_upper (s1_upper),
      .s1_lower (s1_lower),
      .s1_pixel (s1_pixel)
   );

   bb3_window u_window (
      .clock     (clock),
      .reset     (reset),
      .restart   (csr_write),
      .s1_valid  (s1_valid),
      .s1_ctrl   (ctrl1_ff),
      .s1_upper  (s1_upper),
      .s1_lower  (s1_lower),
      .s1_pixel  (s1_pixel),
      .sum_valid (sum_valid),
      .sum       (sum),
      .pending   (pending)
   );

   bb3_out_fifo u_out_fifo (
      .clock          (clock),
      .reset          (reset),
      .push           (sum_valid),
      .push_sum       (sum),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_blur_red   (rsp_blur_red),
      .rsp_blur_green (rsp_blur_green),
      .rsp_blur_blue  (rsp_blur_blue),
      .rsp_frame_end  (rsp_frame_end),
      .count          (fifo_count)
   );

endmodule

// File: design/bb3_line_store.sv
// Two line memories with a read-modify-write pass for each accepted request.
// Depends on bb3_pkg.
module bb3_line_store #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic [$clog2(MAX_WIDTH)-1:0]    addr,
   input  logic [bb3_pkg::PIX_W-1:0]       pixel,
   output logic                            s1_valid,
   output logic [bb3_pkg::PIX_W-1:0]       s1_upper,
   output logic [bb3_pkg::PIX_W-1:0]       s1_lower,
   output logic [bb3_pkg::PIX_W-1:0]       s1_pixel
);
   import bb3_pkg::*;

   localparam int ADDR_W = $clog2(MAX_WIDTH);

   logic [PIX_W-1:0]  upper_mem [MAX_WIDTH];
   logic [PIX_W-1:0]  lower_mem [MAX_WIDTH];
   logic              valid_ff;
   logic              hit_ff;
   logic              hit_in;
   logic [ADDR_W-1:0] addr_ff;
   logic [PIX_W-1:0]  pixel_ff;
   logic [PIX_W-1:0]  rd_upper_ff;
   logic [PIX_W-1:0]  rd_lower_ff;
   logic [PIX_W-1:0]  fwd_upper_ff;
   logic [PIX_W-1:0]  fwd_lower_ff;
   logic [PIX_W-1:0]  upper_eff;
   logic [PIX_W-1:0]  lower_eff;

   // A request reading the entry that the previous request writes back in the
   // same cycle takes the written values instead of the stale read data.
   assign hit_in    = accept && valid_ff && (addr == addr_ff);
   assign upper_eff = hit_ff ? fwd_upper_ff : rd_upper_ff;
   assign lower_eff = hit_ff ? fwd_lower_ff : rd_lower_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         valid_ff <= accept;
         hit_ff   <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         addr_ff      <= addr;
         pixel_ff     <= pixel;
         rd_upper_ff  <= upper_mem[addr];
         rd_lower_ff  <= lower_mem[addr];
         fwd_upper_ff <= lower_eff;
         fwd_lower_ff <= pixel_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (valid_ff) begin
         upper_mem[addr_ff] <= lower_eff;
         lower_mem[addr_ff] <= pixel_ff;
      end
   end

   assign s1_valid = valid_ff;
   assign s1_upper = upper_eff;
   assign s1_lower = lower_eff;
   assign s1_pixel = pixel_ff;

endmodule

// File: design/bb3_window.sv
// 3x3 pixel window and the clipped per-channel sums with rounding offset.
// Depends on bb3_pkg.
module bb3_window (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       restart,
   input  logic                       s1_valid,
   input  bb3_pkg::bb3_ctrl_type      s1_ctrl,
   input  logic [bb3_pkg::PIX_W-1:0]  s1_upper,
   input  logic [bb3_pkg::PIX_W-1:0]  s1_lower,
   input  logic [bb3_pkg::PIX_W-1:0]  s1_pixel,
   output logic                       sum_valid,
   output bb3_pkg::bb3_sum_type       sum,
   output logic [1:0]                 pending
);
   import bb3_pkg::*;

   logic [PIX_W-1:0] win_ff [3][3];
   bb3_ctrl_type     ctrl2_ff;
   logic             v2_ff;
   logic             v3_ff;
   bb3_sum_type      sum_ff;
   bb3_sum_type      sum_in;
   bb3_divisor_type  divisor;
   logic [2:0]       row_en;
   logic [2:0]       col_en;
   logic [SUM_W-1:0] row_sum [3][3];
   logic [SUM_W-1:0] total [3];

   always_comb begin
      divisor = bb3_divisor_of(ctrl2_ff);
      row_en  = {ctrl2_ff.bottom_en, 1'b1, ctrl2_ff.top_en};
      col_en  = {ctrl2_ff.right_en, 1'b1, ctrl2_ff.left_en};
      for (int ch = 0; ch < 3; ch++) begin
         for (int i = 0; i < 3; i++) begin
            row_sum[ch][i] = '0;
            for (int k = 0; k < 3; k++) begin
               if (row_en[i] && col_en[k]) begin
                  row_sum[ch][i] = row_sum[ch][i]
                                 + SUM_W'(win_ff[i][k][PIX_W-1-CH_W*ch -: CH_W]);
               end
            end
         end
         total[ch] = row_sum[ch][0] + row_sum[ch][1] + row_sum[ch][2]
                   + bb3_half_of(divisor);
      end
      sum_in.red       = total[0];
      sum_in.green     = total[1];
      sum_in.blue      = total[2];
      sum_in.divisor   = divisor;
      sum_in.frame_end = ctrl2_ff.frame_end;
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
               win_ff[i][k] <= '0;
            end
         end
      end else if (s1_valid) begin
         for (int i = 0; i < 3; i++) begin
            win_ff[i][0] <= win_ff[i][1];
            win_ff[i][1] <= win_ff[i][2];
         end
         win_ff[0][2] <= s1_upper;
         win_ff[1][2] <= s1_lower;
         win_ff[2][2] <= s1_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v2_ff <= s1_valid && s1_ctrl.result;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid) begin
         ctrl2_ff <= s1_ctrl;
      end
      if (v2_ff) begin
         sum_ff <= sum_in;
      end
   end

   assign sum_valid = v3_ff;
   assign sum       = sum_ff;
   assign pending   = {1'b0, v2_ff} + {1'b0, v3_ff};

endmodule

// File: design/bb3_out_fifo.sv
// Reciprocal scaling of the rounded sums and the result queue to the output.
// Depends on bb3_pkg.
module bb3_out_fifo (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  bb3_pkg::bb3_sum_type            push_sum,
   input  logic                            rsp_stall,
   output logic                            rsp_valid,
   output logic [bb3_pkg::CH_W-1:0]        rsp_blur_red,
   output logic [bb3_pkg::CH_W-1:0]        rsp_blur_green,
   output logic [bb3_pkg::CH_W-1:0]        rsp_blur_blue,
   output logic                            rsp_frame_end,
   output logic [bb3_pkg::FIFO_CNT_W-1:0]  count
);
   import bb3_pkg::*;

   bb3_result_type         fifo_ff [FIFO_DEPTH];
   bb3_result_type         entry_in;
   bb3_result_type         head;
   logic [FIFO_PTR_W-1:0]  wr_ptr_ff;
   logic [FIFO_PTR_W-1:0]  rd_ptr_ff;
   logic [FIFO_CNT_W-1:0]  count_ff;
   logic [FIFO_CNT_W-1:0]  count_in;
   logic [RECIP_W-1:0]     recip;
   logic [PROD_W-1:0]      prod [3];
   logic                   pop;

   always_comb begin
      recip   = bb3_recip(push_sum.divisor);
      prod[0] = PROD_W'(push_sum.red) * PROD_W'(recip);
      prod[1] = PROD_W'(push_sum.green) * PROD_W'(recip);
      prod[2] = PROD_W'(push_sum.blue) * PROD_W'(recip);
      entry_in.red       = prod[0][RECIP_SHIFT +: CH_W];
      entry_in.green     = prod[1][RECIP_SHIFT +: CH_W];
      entry_in.blue      = prod[2][RECIP_SHIFT +: CH_W];
      entry_in.frame_end = push_sum.frame_end;
   end

   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   assign count_in  = count_ff + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= entry_in;
      end
   end

   assign head           = fifo_ff[rd_ptr_ff];
   assign rsp_blur_red   = head.red;
   assign rsp_blur_green = head.green;
   assign rsp_blur_blue  = head.blue;
   assign rsp_frame_end  = head.frame_end;
   assign count          = count_ff;

endmodule

// File: design/bb3_checker.sv
// Port-level checker of the 3x3 box blur unit, bound to the top level.
// Depends on box_blur_3x3_clipped_unit_defines.svh and the top level's ports.
`include "box_blur_3x3_clipped_unit_defines.svh"

module bb3_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [bb3_pkg::CH_W-1:0]        rsp_blur_red,
   input logic [bb3_pkg::CH_W-1:0]        rsp_blur_green,
   input logic [bb3_pkg::CH_W-1:0]        rsp_blur_blue,
   input logic                            rsp_frame_end
);

   `BB3_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid, "result dropped while stalled")
   `BB3_ASSERT(a_rsp_stable, rsp_valid && rsp_stall |=> $stable(rsp_blur_red) && $stable(rsp_blur_green) && $stable(rsp_blur_blue) && $stable(rsp_frame_end), "stalled result changed")
   `BB3_ASSERT_RESET(a_reset_idle, reset |=> !rsp_valid && !req_stall, "queue not empty after reset")
   `BB3_ASSERT_RESET(a_reset_quiet, reset |=> !rsp_valid ##1 !rsp_valid ##1 !rsp_valid, "result too early after reset")

endmodule

bind box_blur_3x3_clipped_unit bb3_checker u_bb3_checker (.*);

// File: bench/box_blur_3x3_clipped_check.sv
// Checker of the 3x3 box blur unit: it follows the APB writes and the request
// channel, predicts every blurred pixel and compares the results in order.
// Depends on bb3_pkg for the register codes and the result layout.
`timescale 1ns / 100ps

module box_blur_3x3_clipped_check (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic                           pready,
   input  logic [bb3_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [bb3_pkg::CSR_DATA_W-1:0] pwdata,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [7:0]                     req_pixel_red,
   input  logic [7:0]                     req_pixel_green,
   input  logic [7:0]                     req_pixel_blue,
   input  logic                           req_drain,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [7:0]                     rsp_blur_red,
   input  logic [7:0]                     rsp_blur_green,
   input  logic [7:0]                     rsp_blur_blue,
   input  logic                           rsp_frame_end,
   output int                             failures,
   output int                             pending,
   output int                             checked
);
   import bb3_pkg::*;

   localparam int          WIDTH_CAP   = 1024;
   localparam int          HEIGHT_CAP  = 4096;
   localparam int          MIN_SIDE    = 2;
   localparam logic [31:0] WIDTH_MASK  = 32'h7FF;
   localparam logic [31:0] HEIGHT_MASK = 32'h1FFF;

   logic [PIX_W-1:0] upper_row_mem [WIDTH_CAP];
   logic [PIX_W-1:0] lower_row_mem [WIDTH_CAP];
   logic [PIX_W-1:0] win [3][3];
   int               frame_w;
   int               frame_h;
   int               col_pos;
   int               row_pos;
   bb3_result_type   blur_expected [$];
   int               fail_count = 0;
   int               result_count = 0;

   function automatic int clamp_side(input logic [31:0] value, input int hi);
      if (value < MIN_SIDE) begin
         return MIN_SIDE;
      end
      if (value > hi) begin
         return hi;
      end
      return int'(value);
   endfunction

   task automatic restart_frame();
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            win[i][k] = '0;
         end
      end
      col_pos = 0;
      row_pos = 0;
   endtask

   task automatic blur_predict(input logic [PIX_W-1:0] rgb, input logic drain);
      logic [PIX_W-1:0] pix;
      logic [PIX_W-1:0] up;
      logic [PIX_W-1:0] lo;
      logic [7:0]       avg [3];
      int               c;
      int               r;
      int               cr;
      int               cc;
      int               r0;
      int               r1;
      int               c0;
      int               c1;
      int               n;
      int               sum;
      bit               hit;
      bb3_result_type   want;
      c = col_pos;
      r = row_pos;
      pix = (!drain && r < frame_h) ? rgb : '0;
      up = upper_row_mem[c];
      lo = lower_row_mem[c];
      upper_row_mem[c] = lo;
      lower_row_mem[c] = pix;
      for (int i = 0; i < 3; i++) begin
         win[i][0] = win[i][1];
         win[i][1] = win[i][2];
      end
      win[0][2] = up;
      win[1][2] = lo;
      win[2][2] = pix;

      // The window center trails the incoming position by one row and one pixel.
      if (c >= 1) begin
         hit = (r >= 1);
         cr = (r >= 1) ? r - 1 : r;
         cc = c - 1;
      end else begin
         hit = (r >= 2);
         cr = (r >= 2) ? r - 2 : r;
         cc = frame_w - 1;
      end
      hit = hit && (cr < frame_h);
      want.frame_end = 1'b0;
      if (hit) begin
         r0 = (cr > 0) ? 0 : 1;
         r1 = (cr < frame_h - 1) ? 2 : 1;
         c0 = (cc > 0) ? 0 : 1;
         c1 = (cc < frame_w - 1) ? 2 : 1;
         n = (r1 - r0 + 1) * (c1 - c0 + 1);
         for (int ch = 0; ch < 3; ch++) begin
            sum = 0;
            for (int i = r0; i <= r1; i++) begin
               for (int k = c0; k <= c1; k++) begin
                  sum += (win[i][k] >> (16 - 8 * ch)) & 'hFF;
               end
            end
            avg[ch] = 8'((sum + n / 2) / n);
         end
         want.red = avg[0];
         want.green = avg[1];
         want.blue = avg[2];
         want.frame_end = (cr == frame_h - 1 && cc == frame_w - 1);
         blur_expected.push_back(want);
      end

      if (want.frame_end) begin
         c = 0;
         r = 0;
      end else begin
         c++;
         if (c >= frame_w) begin
            c = 0;
            r++;
         end
      end
      col_pos = c;
      row_pos = r;
   endtask

   task automatic blur_compare();
      bb3_result_type got;
      bb3_result_type want;
      got.red = rsp_blur_red;
      got.green = rsp_blur_green;
      got.blue = rsp_blur_blue;
      got.frame_end = rsp_frame_end;
      result_count++;
      if (blur_expected.size() == 0) begin
         fail_count++;
         $display("%0t: unexpected result rgb=%0d,%0d,%0d frame_end=%0b", $time,
                  got.red, got.green, got.blue, got.frame_end);
      end else begin
         want = blur_expected.pop_front();
         if (got !== want) begin
            fail_count++;
            $display("%0t: mismatch, expected rgb=%0d,%0d,%0d frame_end=%0b,",
                     $time, want.red, want.green, want.blue, want.frame_end,
                     " got rgb=%0d,%0d,%0d frame_end=%0b",
                     got.red, got.green, got.blue, got.frame_end);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         frame_w = FRAME_WIDTH_RESET;
         frame_h = FRAME_HEIGHT_RESET;
         foreach (upper_row_mem[k]) begin
            upper_row_mem[k] = '0;
            lower_row_mem[k] = '0;
         end
         restart_frame();
         blur_expected.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (bb3_reg_type'(paddr[2]))
               REG_FRAME_WIDTH: begin
                  frame_w = clamp_side(pwdata & WIDTH_MASK, WIDTH_CAP);
               end
               REG_FRAME_HEIGHT: begin
                  frame_h = clamp_side(pwdata & HEIGHT_MASK, HEIGHT_CAP);
               end
               default: begin
               end
            endcase
            restart_frame();
         end
         if (rsp_valid && !rsp_stall) begin
            blur_compare();
         end
         if (req_valid && !req_stall) begin
            blur_predict({req_pixel_red, req_pixel_green, req_pixel_blue}, req_drain);
         end
      end
      failures <= fail_count;
      pending <= blur_expected.size();
      checked <= result_count;
   end

endmodule

// File: bench/box_blur_3x3_clipped_unit_test.sv
// Top of the 3x3 box blur test: clock, reset, APB writes and pixel requests,
// with random gaps on both channels; the checker module judges every result.
// Depends on bb3_pkg, box_blur_3x3_clipped_unit and box_blur_3x3_clipped_check.
`timescale 1ns / 100ps

module box_blur_3x3_clipped_unit_test;
   import bb3_pkg::*;

   localparam int RANDOM_ITEMS  = 1150;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 300;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int WIDE_CUT      = 300;
   localparam int NOISE_ITEMS   = 40;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [CH_W-1:0]       req_pixel_red = '0;
   logic [CH_W-1:0]       req_pixel_green = '0;
   logic [CH_W-1:0]       req_pixel_blue = '0;
   logic                  req_drain = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [CH_W-1:0]       rsp_blur_red;
   logic [CH_W-1:0]       rsp_blur_green;
   logic [CH_W-1:0]       rsp_blur_blue;
   logic                  rsp_frame_end;

   int blur_failures;
   int blur_pending;
   int blur_checked;
   int requests_sent = 0;
   int drains_sent = 0;
   int reg_writes = 0;
   int sender_gap_pct = 25;
   int receiver_stall_pct = 51;
   int hold_trigger = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int cycle_count = 0;

   always #5 clock = ~clock;

   box_blur_3x3_clipped_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel_red  (req_pixel_red),
      .req_pixel_green(req_pixel_green),
      .req_pixel_blue (req_pixel_blue),
      .req_drain      (req_drain),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_blur_red   (rsp_blur_red),
      .rsp_blur_green (rsp_blur_green),
      .rsp_blur_blue  (rsp_blur_blue),
      .rsp_frame_end  (rsp_frame_end)
   );

   box_blur_3x3_clipped_check i_check (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .pready         (pready),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel_red  (req_pixel_red),
      .req_pixel_green(req_pixel_green),
      .req_pixel_blue (req_pixel_blue),
      .req_drain      (req_drain),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_blur_red   (rsp_blur_red),
      .rsp_blur_green (rsp_blur_green),
      .rsp_blur_blue  (rsp_blur_blue),
      .rsp_frame_end  (rsp_frame_end),
      .failures       (blur_failures),
      .pending        (blur_pending),
      .checked        (blur_checked)
   );

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_seen != hold_trigger) begin
         hold_seen <= hold_trigger;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic cfg_write(input bb3_reg_type sel, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_ADDR_W'({sel, 2'b00});
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      reg_writes++;
   endtask

   task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue, input logic drain);
      while ($urandom_range(99) < sender_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_red <= red;
      req_pixel_green <= green;
      req_pixel_blue <= blue;
      req_drain <= drain;
      do @(posedge clock); while (req_stall);
      requests_sent++;
      if (drain) begin
         drains_sent++;
      end
   endtask

   // Waits until every predicted result is out, then lets the pipeline empty.
   task automatic wait_quiet();
      req_valid <= 1'b0;
      do @(posedge clock); while (blur_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_frame(input int w, input int h, input int cut, input bit pause_mid);
      int  total;
      bit  drain;
      total = w * h + w + 1;
      for (int pos = 0; pos < total && pos != cut; pos++) begin
         if (pause_mid && pos == w * h / 2) begin
            wait_quiet();
         end
         if (pos < w * h) begin
            drain = ($urandom_range(99) < 3);
         end else begin
            drain = ($urandom_range(99) >= 10);
         end
         send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)), drain);
      end
   endtask

   initial begin
      int phase_no;
      int skip_count;
      int w;
      int h;
      int frames;
      int cut;
      int done;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Both sizes below the range clamp to the smallest 2x2 frame.
      cfg_write(REG_FRAME_WIDTH, 32'd0);
      cfg_write(REG_FRAME_HEIGHT, 32'd1);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
      send_pixel(8'd255, 8'd0, 8'd1, 1'b0);
      send_pixel(8'd0, 8'd255, 8'd254, 1'b0);
      repeat (3) send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
      wait_quiet();

      // Upper bits are dropped, giving a 3x3 frame with a drain in the middle
      // and a pixel among the flush requests.
      cfg_write(REG_FRAME_WIDTH, 32'hFFFF_F803);
      cfg_write(REG_FRAME_HEIGHT, 32'hFFFF_E003);
      send_pixel(8'd1, 8'd2, 8'd255, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
      send_pixel(8'd255, 8'd128, 8'd3, 1'b0);
      send_pixel(8'd254, 8'd1, 8'd0, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
      send_pixel(8'd128, 8'd127, 8'd255, 1'b0);
      send_pixel(8'd0, 8'd255, 8'd5, 1'b0);
      send_pixel(8'd3, 8'd0, 8'd255, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd0, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
      send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
      wait_quiet();

      skip_count = requests_sent;
      phase_no = 0;
      while (requests_sent - skip_count < RANDOM_ITEMS) begin
         phase_no++;
         done = requests_sent - skip_count;
         if (done < RANDOM_ITEMS / 3) begin
            sender_gap_pct = 25;
            receiver_stall_pct <= 51;
         end else if (done < 2 * RANDOM_ITEMS / 3) begin
            sender_gap_pct = 51;
            receiver_stall_pct <= 25;
         end else begin
            sender_gap_pct = 0;
            receiver_stall_pct <= 0;
         end

         if (phase_no == 4) begin
            // Widest frame and tallest height, cut inside the first row.
            cfg_write(REG_FRAME_WIDTH, 32'h0000_07FF);
            cfg_write(REG_FRAME_HEIGHT, 32'h0000_1FFF);
            send_frame(1024, 4096, WIDE_CUT, 1'b0);
         end else if (phase_no > 5 && $urandom_range(99) < 10) begin
            cfg_write(REG_FRAME_WIDTH, $urandom);
            cfg_write(REG_FRAME_HEIGHT, $urandom);
            repeat (NOISE_ITEMS) begin
               send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                          8'($urandom_range(255)), $urandom_range(99) < 3);
            end
         end else begin
            w = ($urandom_range(99) < 15) ? 2 : $urandom_range(12, 2);
            h = $urandom_range(9, 2);
            if (phase_no == 2) begin
               w = 12;
               h = 10;
            end
            cfg_write(REG_FRAME_WIDTH, w);
            cfg_write(REG_FRAME_HEIGHT, h);
            frames = $urandom_range(3, 1);
            for (int f = 0; f < frames; f++) begin
               cut = (phase_no > 5 && $urandom_range(99) < 10) ?
                     $urandom_range(w * h + w, 1) : -1;
               if (phase_no == 2 && f == 0) begin
                  hold_trigger <= hold_trigger + 1;
               end
               send_frame(w, h, cut, phase_no == 5 && f == 0);
               if (cut >= 0) begin
                  break;
               end
            end
         end
         wait_quiet();
      end

      $display("Covered %0d requests, %0d of them drain ticks, and %0d checked blur results",
               requests_sent, drains_sent, blur_checked);
      $display("over %0d register writes, frames from 2x2 up to 1024 columns, stalls on both sides.",
               reg_writes);
      if (blur_failures == 0 && blur_pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
